// ===== hw/rtl/ggvc_pkg.sv =====
// ----------------------------------------------------------------------------
// ggvc_pkg
// Shared constants, widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ggvc_pkg;

    localparam int CoordW   = 16;
    localparam int HeadW    = 15;
    localparam int GainW    = 16;
    localparam int SpeedW   = 15;
    localparam int DiffW    = 17;
    localparam int SqW      = 35;
    localparam int DistW    = 18;
    localparam int CordW    = 30;
    localparam int AngW     = 23;
    localparam int Steps    = 20;
    localparam int SqrtSteps = 18;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CfgTargetX    = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgTargetY    = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgGain       = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgSpeedLimit = 2'd3;

    localparam logic [DistW-1:0]      DistMin  = 18'd102;
    localparam logic [HeadW:0]        AngMin   = 16'd819;
    localparam logic signed [AngW-1:0] HalfPi  = 23'sd1647099;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [HeadW-1:0]  heading;
    } t_pose;

    typedef struct packed {
        logic [SpeedW-1:0] linear_speed;
        logic [SpeedW-1:0] angular_speed;
    } t_cmd;

    function automatic logic signed [AngW-1:0] atan_tab(input logic [4:0] i);
        logic signed [AngW-1:0] r;
        case (i)
            5'd0:  r = 23'sd823550;
            5'd1:  r = 23'sd486170;
            5'd2:  r = 23'sd256879;
            5'd3:  r = 23'sd130396;
            5'd4:  r = 23'sd65451;
            5'd5:  r = 23'sd32757;
            5'd6:  r = 23'sd16383;
            5'd7:  r = 23'sd8192;
            5'd8:  r = 23'sd4096;
            5'd9:  r = 23'sd2048;
            5'd10: r = 23'sd1024;
            5'd11: r = 23'sd512;
            5'd12: r = 23'sd256;
            5'd13: r = 23'sd128;
            5'd14: r = 23'sd64;
            5'd15: r = 23'sd32;
            5'd16: r = 23'sd16;
            5'd17: r = 23'sd8;
            5'd18: r = 23'sd4;
            5'd19: r = 23'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/ggvc_if.sv =====
// ----------------------------------------------------------------------------
// ggvc_if
// Valid/ready stream channel carrying one payload word.
// ----------------------------------------------------------------------------
interface ggvc_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ggvc_pipe.sv =====
// ----------------------------------------------------------------------------
// ggvc_pipe
// Pipelined datapath: differences, square root, CORDIC bearing, command.
// Stage 0 forms dx, dy, d2; stages 1..20 run one CORDIC step each, the first
// SqrtSteps also a root step; 21 the error; 22 the gain product; 23 output.
// Whole pipe advances on i_en, so a stall freezes every stage.
// ----------------------------------------------------------------------------
module ggvc_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  ggvc_pkg::t_pose               i_pose,
    input  logic signed [ggvc_pkg::CoordW-1:0] i_target_x,
    input  logic signed [ggvc_pkg::CoordW-1:0] i_target_y,
    input  logic [ggvc_pkg::GainW-1:0]    i_gain,
    input  logic [ggvc_pkg::SpeedW-1:0]   i_speed_limit,
    output logic                          o_valid,
    output ggvc_pkg::t_cmd                o_cmd
);
    import ggvc_pkg::*;

    localparam int N = Steps;      // CORDIC stages; root uses first SqrtSteps

    // stage 0 registers
    logic                     r_v0;
    logic signed [DiffW-1:0]  r_dx0, r_dy0;
    logic [SqW-1:0]           r_sq0;
    logic signed [HeadW-1:0]  r_hd0;
    logic signed [DiffW-1:0]  n_dx, n_dy;
    logic signed [2*DiffW-1:0] n_px, n_py;

    assign n_dx = DiffW'(i_target_x) - DiffW'(i_pose.pos_x);
    assign n_dy = DiffW'(i_target_y) - DiffW'(i_pose.pos_y);
    assign n_px = n_dx * n_dx;
    assign n_py = n_dy * n_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
        if (i_en) begin
            r_dx0 <= n_dx;
            r_dy0 <= n_dy;
            r_sq0 <= SqW'($unsigned(n_px)) + SqW'($unsigned(n_py));
            r_hd0 <= i_pose.heading;
        end
    end

    // CORDIC and root stages
    logic                     r_v  [N+1];
    logic signed [CordW-1:0]  r_x  [N+1];
    logic signed [CordW-1:0]  r_y  [N+1];
    logic signed [AngW-1:0]   r_z  [N+1];
    logic                     r_zr [N+1];
    logic signed [HeadW-1:0]  r_hd [N+1];
    logic [SqW+1:0]           r_rem[N+1];
    logic [DistW-1:0]         r_res[N+1];

    // pre-rotation into stage slot 0 (combinational from stage 0 regs)
    logic signed [CordW-1:0] n_x0, n_y0, n_xs, n_ys;
    logic signed [AngW-1:0]  n_z0;
    always_comb begin
        n_xs = CordW'(r_dx0) <<< 8;
        n_ys = CordW'(r_dy0) <<< 8;
        n_x0 = n_xs;
        n_y0 = n_ys;
        n_z0 = '0;
        if (n_xs < 0) begin
            if (n_ys >= 0) begin
                n_x0 = n_ys; n_y0 = -n_xs; n_z0 = HalfPi;
            end else begin
                n_x0 = -n_ys; n_y0 = n_xs; n_z0 = -HalfPi;
            end
        end
    end

    assign r_v[0]   = r_v0;
    assign r_x[0]   = n_x0;
    assign r_y[0]   = n_y0;
    assign r_z[0]   = n_z0;
    assign r_zr[0]  = (r_dx0 == '0) && (r_dy0 == '0);
    assign r_hd[0]  = r_hd0;
    assign r_rem[0] = (SqW+2)'(r_sq0);
    assign r_res[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [CordW-1:0] n_xo, n_yo;
        logic signed [AngW-1:0]  n_zo;
        logic [SqW+1:0]          n_rem;
        logic [DistW-1:0]        n_res;
        always_comb begin
            if (r_y[i] > 0) begin
                n_xo = r_x[i] + (r_y[i] >>> i);
                n_yo = r_y[i] - (r_x[i] >>> i);
                n_zo = r_z[i] + atan_tab(5'(i));
            end else begin
                n_xo = r_x[i] - (r_y[i] >>> i);
                n_yo = r_y[i] + (r_x[i] >>> i);
                n_zo = r_z[i] - atan_tab(5'(i));
            end
        end
        if (i < SqrtSteps) begin : g_root
            localparam int Sh = 2 * (SqrtSteps - 1 - i);
            logic [SqW+1:0] n_trial;
            always_comb begin
                n_trial = (SqW+2)'({r_res[i], 2'b01}) << Sh;
                if (r_rem[i] >= n_trial) begin
                    n_rem = r_rem[i] - n_trial;
                    n_res = {r_res[i][DistW-2:0], 1'b1};
                end else begin
                    n_rem = r_rem[i];
                    n_res = {r_res[i][DistW-2:0], 1'b0};
                end
            end
        end else begin : g_hold
            assign n_rem = r_rem[i];
            assign n_res = r_res[i];
        end
        logic                    r_vs, r_zrs;
        logic signed [CordW-1:0] r_xs, r_ys;
        logic signed [AngW-1:0]  r_zs;
        logic signed [HeadW-1:0] r_hds;
        logic [SqW+1:0]          r_rems;
        logic [DistW-1:0]        r_ress;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs <= 1'b0;
            end else if (i_en) begin
                r_vs <= r_v[i];
            end
            if (i_en) begin
                r_xs   <= n_xo;
                r_ys   <= n_yo;
                r_zs   <= n_zo;
                r_zrs  <= r_zr[i];
                r_hds  <= r_hd[i];
                r_rems <= n_rem;
                r_ress <= n_res;
            end
        end
        assign r_v[i+1]   = r_vs;
        assign r_x[i+1]   = r_xs;
        assign r_y[i+1]   = r_ys;
        assign r_z[i+1]   = r_zs;
        assign r_zr[i+1]  = r_zrs;
        assign r_hd[i+1]  = r_hds;
        assign r_rem[i+1] = r_rems;
        assign r_res[i+1] = r_ress;
    end

    // error stage
    logic signed [AngW-1:0] n_zq;
    logic signed [HeadW+1:0] n_bear, n_err;
    assign n_zq   = (r_z[N] + AngW'(128)) >>> 8;
    assign n_bear = r_zr[N] ? '0 : (HeadW+2)'(n_zq);
    assign n_err  = n_bear - (HeadW+2)'(r_hd[N]);

    logic              r_ve, r_near, r_turn;
    logic [HeadW:0]    r_aerr;
    logic [DistW-1:0]  r_dist;
    logic [HeadW:0]    n_aerr;
    assign n_aerr = n_err[HeadW+1] ? (HeadW+1)'(-n_err) : (HeadW+1)'(n_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (i_en) begin
            r_ve <= r_v[N];
        end
        if (i_en) begin
            r_near <= r_res[N] <= DistMin;
            r_aerr <= n_aerr;
            r_turn <= n_aerr > AngMin;
            r_dist <= r_res[N];
        end
    end

    // product stage
    logic              r_vp, r_nearp, r_turnp;
    logic [HeadW:0]    r_aerrp;
    logic [GainW+DistW-1:0] r_prod;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (i_en) begin
            r_vp <= r_ve;
        end
        if (i_en) begin
            r_nearp <= r_near;
            r_turnp <= r_turn;
            r_aerrp <= r_aerr;
            r_prod  <= (GainW+DistW)'(i_gain) * (GainW+DistW)'(r_dist);
        end
    end

    // command stage
    logic [GainW+DistW-11:0] n_lin;
    t_cmd n_cmd;
    always_comb begin
        n_lin = r_prod[GainW+DistW-1:10];
        n_cmd = '0;
        if (!r_nearp) begin
            if (r_turnp) begin
                n_cmd.angular_speed = SpeedW'(r_aerrp);
            end else if (n_lin > (GainW+DistW-10)'(i_speed_limit)) begin
                n_cmd.linear_speed = i_speed_limit;
            end else begin
                n_cmd.linear_speed = SpeedW'(n_lin);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vp;
        end
        if (i_en) begin
            o_cmd <= n_cmd;
        end
    end

endmodule

// ===== hw/rtl/go_to_goal_velocity_controller.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_velocity_controller
// Proportional go-to-goal controller: pose word in, speed command word out.
// ----------------------------------------------------------------------------
// One pose word is taken every clock unless the output stalls; each gives
// one command word after the difference/square stage, 20 CORDIC steps (the
// first SqrtSteps also root steps), error, gain product and output stages.
// The whole pipe advances while the output stage is empty or being taken,
// so a stall at the output holds every stage. Target, gain and limit are
// written through the write port; only while idle, as the user must ensure.
module go_to_goal_velocity_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ggvc_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [ggvc_pkg::CfgDataW-1:0]     i_cfg_data,
    ggvc_if.sink                              s_pose,
    ggvc_if.source                            m_cmd
);
    import ggvc_pkg::*;

    logic signed [CoordW-1:0] r_target_x, r_target_y;
    logic [GainW-1:0]         r_gain;
    logic [SpeedW-1:0]        r_speed_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x    <= 16'sd1024;
            r_target_y    <= 16'sd1024;
            r_gain        <= 16'd1024;
            r_speed_limit <= 15'd3072;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgTargetX:    r_target_x    <= i_cfg_data;
                CfgTargetY:    r_target_y    <= i_cfg_data;
                CfgGain:       r_gain        <= i_cfg_data;
                CfgSpeedLimit: r_speed_limit <= i_cfg_data[SpeedW-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic out_valid;
    t_pose pose;
    t_cmd  cmd;

    assign en           = !out_valid || m_cmd.ready;
    assign s_pose.ready = en;
    assign pose         = s_pose.data;

    ggvc_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (s_pose.valid),
        .i_pose        (pose),
        .i_target_x    (r_target_x),
        .i_target_y    (r_target_y),
        .i_gain        (r_gain),
        .i_speed_limit (r_speed_limit),
        .o_valid       (out_valid),
        .o_cmd         (cmd)
    );

    assign m_cmd.valid = out_valid;
    assign m_cmd.data  = cmd;

endmodule
